// ===== sv/video_register_timer_block_assert.svh =====
// assertion macros for the video register timer block
// used by modules that check their own control logic, clock is i_clk
`ifndef VIDEO_REGISTER_TIMER_BLOCK_ASSERT_SVH
`define VIDEO_REGISTER_TIMER_BLOCK_ASSERT_SVH
`ifndef SYNTHESIS
`define VRTB_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("vrtb assertion failed");
`define VRTB_ASSERT_NORST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("vrtb assertion failed");
`else
`define VRTB_ASSERT(label, prop)
`define VRTB_ASSERT_NORST(label, prop)
`endif
`endif

// ===== sv/vrtb_pkg.sv =====
// shared types, constants and helpers of the video register timer block
// no dependencies
`default_nettype none

package vrtb_pkg;

    localparam int VBLANK_LINE     = 248;
    localparam int PIXELS_PER_LINE = 384;
    localparam int VRAM_WORDS      = 34816;
    localparam int VRAM_AW         = $clog2(VRAM_WORDS);
    localparam int Q_DEPTH         = 2;
    localparam int Q_PW            = $clog2(Q_DEPTH);
    localparam int Q_CW            = $clog2(Q_DEPTH + 1);

    localparam logic [15:0] SPRITE_MASK = 16'h87ff;
    localparam logic [15:0] MAIN_MASK   = 16'h7fff;
    localparam logic [8:0]  RASTER_OFS  = 9'h0f8;

    // bus register numbers
    localparam logic [2:0] REG_ADDR   = 3'd0;
    localparam logic [2:0] REG_DATA   = 3'd1;
    localparam logic [2:0] REG_STEP   = 3'd2;
    localparam logic [2:0] REG_MODE   = 3'd3;
    localparam logic [2:0] REG_RLD_HI = 3'd4;
    localparam logic [2:0] REG_RLD_LO = 3'd5;
    localparam logic [2:0] REG_ACK    = 3'd6;
    localparam logic [2:0] REG_NONE   = 3'd7;

    typedef enum logic [1:0] {
        FN_READ  = 2'd0,
        FN_WRITE = 2'd1,
        FN_FRAME = 2'd2,
        FN_LINE  = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        OP_READ_BUF,
        OP_READ_STEP,
        OP_READ_RASTER,
        OP_WR_ADDR,
        OP_WR_DATA,
        OP_WR_STEP,
        OP_WR_MODE,
        OP_WR_RLD_HI,
        OP_WR_RLD_LO,
        OP_WR_ACK,
        OP_NOP,
        OP_FRAME,
        OP_LINE
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_EXEC,
        ST_FETCH
    } t_back_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  reg_index;
        logic [15:0] write_data;
        logic [8:0]  line_number;
    } t_in_word;

    typedef struct packed {
        logic [15:0] read_data;
        logic        vblank_pending;
        logic        timer_pending;
        logic        reset_pending;
    } t_out_word;

    typedef struct packed {
        t_op         op;
        logic [15:0] data;
        logic [8:0]  line;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // vram index of a bus address, sprite window folds onto 0x8000..0x87ff
    function automatic logic [VRAM_AW-1:0] ram_slot(input logic [15:0] addr);
        logic [15:0] s;
        s = addr[15] ? (addr & SPRITE_MASK) : (addr & MAIN_MASK);
        return VRAM_AW'(s);
    endfunction

endpackage

`default_nettype wire

// ===== sv/vrtb_front.sv =====
// front end: takes bus words, decodes them into commands, pushes the queue
// depends on vrtb_pkg
`default_nettype none

module vrtb_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire vrtb_pkg::t_in_word i_in_word,
    input  wire logic              i_clearing,
    input  wire vrtb_pkg::t_q_stat i_q_stat,
    output logic                   o_push,
    output vrtb_pkg::t_cmd         o_cmd
);
    import vrtb_pkg::*;

    logic r_cmd_valid, n_cmd_valid;
    t_cmd r_cmd;
    logic accept;

    function automatic t_op decode(input logic [1:0] fn, input logic [2:0] idx);
        t_op op;
        op = OP_NOP;
        case (t_func'(fn))
            FN_READ: begin
                case (idx) inside
                    REG_ADDR, REG_DATA, REG_RLD_HI, REG_RLD_LO: op = OP_READ_BUF;
                    REG_STEP, REG_ACK:                          op = OP_READ_STEP;
                    default:                                    op = OP_READ_RASTER;
                endcase
            end
            FN_WRITE: begin
                case (idx)
                    REG_ADDR:   op = OP_WR_ADDR;
                    REG_DATA:   op = OP_WR_DATA;
                    REG_STEP:   op = OP_WR_STEP;
                    REG_MODE:   op = OP_WR_MODE;
                    REG_RLD_HI: op = OP_WR_RLD_HI;
                    REG_RLD_LO: op = OP_WR_RLD_LO;
                    REG_ACK:    op = OP_WR_ACK;
                    REG_NONE:   op = OP_NOP;
                    default:    op = OP_NOP;
                endcase
            end
            FN_FRAME: op = OP_FRAME;
            FN_LINE:  op = OP_LINE;
            default:  op = OP_NOP;
        endcase
        return op;
    endfunction

    assign o_push     = r_cmd_valid && !i_q_stat.full;
    assign o_in_stall = i_clearing || (r_cmd_valid && i_q_stat.full);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd_valid = r_cmd_valid;
        if (accept) begin
            n_cmd_valid = 1'b1;
        end else if (o_push) begin
            n_cmd_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else begin
            r_cmd_valid <= n_cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.op   <= decode(i_in_word.func, i_in_word.reg_index);
            r_cmd.data <= i_in_word.write_data;
            r_cmd.line <= i_in_word.line_number;
        end
    end

endmodule

`default_nettype wire

// ===== sv/vrtb_fifo.sv =====
// short command queue between the front end and the execution back end
// depends on vrtb_pkg
`default_nettype none

module vrtb_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire vrtb_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output vrtb_pkg::t_q_stat   o_stat,
    output vrtb_pkg::t_cmd      o_head
);
    import vrtb_pkg::*;

    t_cmd r_mem [Q_DEPTH];
    logic [Q_PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0] r_count, n_count;

    assign o_stat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/vrtb_back.sv =====
// back end: register file, line timer, animation counter, vram and result word
// depends on vrtb_pkg and the assertion macro header
`default_nettype none
`include "video_register_timer_block_assert.svh"

module vrtb_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vrtb_pkg::t_q_stat i_q_stat,
    input  wire vrtb_pkg::t_cmd    i_cmd,
    output logic                   o_pop,
    output logic                   o_clearing,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output vrtb_pkg::t_out_word    o_out_word
);
    import vrtb_pkg::*;

    t_back_state r_state, n_state;

    logic [15:0] r_vram [VRAM_WORDS];
    logic [VRAM_AW-1:0] r_clr_addr;
    logic [15:0] r_prefetch;

    logic [15:0] r_ram_address, n_ram_address;
    logic [15:0] r_address_step, n_address_step;
    logic [15:0] r_mode_word, n_mode_word;
    logic [7:0]  r_anim_period, n_anim_period;
    logic [2:0]  r_timer_mode, n_timer_mode;
    logic        r_timer_on, n_timer_on;
    logic [31:0] r_reload, n_reload;
    logic [31:0] r_count, n_count;
    logic        r_vblank, n_vblank;
    logic        r_timer_flag, n_timer_flag;
    logic        r_reset_flag, n_reset_flag;
    logic [2:0]  r_anim_counter, n_anim_counter;
    logic [8:0]  r_anim_frames, n_anim_frames;
    logic [8:0]  r_line, n_line;

    logic        r_out_valid, n_out_valid;
    t_out_word   r_out_word;
    logic [15:0] rd_value;

    logic out_free, exec_en, ram_we, ram_re, clear_done;
    logic [VRAM_AW-1:0] ram_wa;
    logic [15:0] ram_wd;
    logic [31:0] cnt_base, reload_next;
    logic [8:0]  frames_inc, raster_line;
    logic [9:0]  period_len;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign clear_done = (r_clr_addr == VRAM_AW'(VRAM_WORDS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (clear_done) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (exec_en && (i_cmd.op == OP_WR_ADDR || i_cmd.op == OP_WR_DATA)) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: n_state = ST_EXEC;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        o_clearing = 1'b0;
        exec_en    = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_wa     = ram_slot(r_ram_address);
        ram_wd     = i_cmd.data;
        case (r_state)
            ST_CLEAR: begin
                o_clearing = 1'b1;
                ram_we     = 1'b1;
                ram_wa     = r_clr_addr;
                ram_wd     = '0;
            end
            ST_EXEC: begin
                exec_en = !i_q_stat.empty && out_free;
                ram_we  = exec_en && (i_cmd.op == OP_WR_DATA);
            end
            ST_FETCH: ram_re = 1'b1;
            default: ;
        endcase
    end

    assign o_pop = exec_en;

    // line timer and animation helpers
    assign cnt_base    = r_timer_mode[0] ? r_reload : r_count;
    assign reload_next = {r_reload[31:16], i_cmd.data};
    assign frames_inc  = r_anim_frames + 1'b1;
    assign period_len  = {2'b00, r_anim_period} + 10'd1;
    assign raster_line = r_line + RASTER_OFS;

    always_comb begin
        n_ram_address  = r_ram_address;
        n_address_step = r_address_step;
        n_mode_word    = r_mode_word;
        n_anim_period  = r_anim_period;
        n_timer_mode   = r_timer_mode;
        n_timer_on     = r_timer_on;
        n_reload       = r_reload;
        n_count        = r_count;
        n_vblank       = r_vblank;
        n_timer_flag   = r_timer_flag;
        n_reset_flag   = r_reset_flag;
        n_anim_counter = r_anim_counter;
        n_anim_frames  = r_anim_frames;
        n_line         = r_line;
        rd_value       = '0;
        if (exec_en) begin
            case (i_cmd.op)
                OP_READ_BUF:    rd_value = r_prefetch;
                OP_READ_STEP:   rd_value = r_address_step;
                OP_READ_RASTER: rd_value = {raster_line, 4'b0000, r_anim_counter};
                OP_WR_ADDR:     n_ram_address = i_cmd.data;
                OP_WR_DATA: begin
                    // step wraps inside 15 bits, window bit stays
                    n_ram_address = {r_ram_address[15],
                                     r_ram_address[14:0] + r_address_step[14:0]};
                end
                OP_WR_STEP:     n_address_step = i_cmd.data;
                OP_WR_MODE: begin
                    n_mode_word   = i_cmd.data;
                    n_anim_period = i_cmd.data[15:8];
                    n_timer_mode  = i_cmd.data[6:4];
                    n_timer_on    = i_cmd.data[4];
                end
                OP_WR_RLD_HI:   n_reload = {i_cmd.data, r_reload[15:0]};
                OP_WR_RLD_LO: begin
                    n_reload = reload_next;
                    if (!r_timer_mode[0]) n_count = reload_next;
                end
                OP_WR_ACK: begin
                    if (i_cmd.data[2]) n_vblank     = 1'b0;
                    if (i_cmd.data[1]) n_timer_flag = 1'b0;
                    if (i_cmd.data[0]) n_reset_flag = 1'b0;
                end
                OP_FRAME: begin
                    n_line = '0;
                    if (!r_mode_word[3]) begin
                        if ({1'b0, frames_inc} >= period_len) begin
                            n_anim_frames  = '0;
                            n_anim_counter = r_anim_counter + 1'b1;
                        end else begin
                            n_anim_frames = frames_inc;
                        end
                    end
                    if (r_timer_on && r_timer_mode[1]) n_count = r_reload;
                end
                OP_LINE: begin
                    n_line = i_cmd.line;
                    if (r_timer_on) begin
                        if (cnt_base <= 32'(PIXELS_PER_LINE)) begin
                            n_timer_flag = 1'b1;
                            n_count      = r_reload;
                        end else begin
                            n_count = cnt_base - 32'(PIXELS_PER_LINE);
                        end
                    end
                    if (i_cmd.line == 9'(VBLANK_LINE)) n_vblank = 1'b1;
                end
                OP_NOP: ;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (exec_en) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr_addr     <= '0;
            r_ram_address  <= '0;
            r_address_step <= 16'd1;
            r_mode_word    <= '0;
            r_anim_period  <= '0;
            r_timer_mode   <= '0;
            r_timer_on     <= 1'b0;
            r_reload       <= '0;
            r_count        <= '0;
            r_vblank       <= 1'b0;
            r_timer_flag   <= 1'b0;
            r_reset_flag   <= 1'b1;
            r_anim_counter <= '0;
            r_anim_frames  <= '0;
            r_line         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            if (r_state == ST_CLEAR && !clear_done) r_clr_addr <= r_clr_addr + 1'b1;
            r_ram_address  <= n_ram_address;
            r_address_step <= n_address_step;
            r_mode_word    <= n_mode_word;
            r_anim_period  <= n_anim_period;
            r_timer_mode   <= n_timer_mode;
            r_timer_on     <= n_timer_on;
            r_reload       <= n_reload;
            r_count        <= n_count;
            r_vblank       <= n_vblank;
            r_timer_flag   <= n_timer_flag;
            r_reset_flag   <= n_reset_flag;
            r_anim_counter <= n_anim_counter;
            r_anim_frames  <= n_anim_frames;
            r_line         <= n_line;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_en) begin
            r_out_word.read_data      <= rd_value;
            r_out_word.vblank_pending <= n_vblank;
            r_out_word.timer_pending  <= n_timer_flag;
            r_out_word.reset_pending  <= n_reset_flag;
        end
    end

    // vram write port
    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_vram[ram_wa] <= ram_wd;
        end
    end

    // vram read port, the read buffer is the registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefetch <= '0;
        end else if (ram_re) begin
            r_prefetch <= r_vram[ram_slot(r_ram_address)];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `VRTB_ASSERT_NORST(a_reset_starts_clear, $past(!i_rst_n) |-> (r_state == ST_CLEAR))
    `VRTB_ASSERT(a_no_exec_while_clear, (r_state == ST_CLEAR) |-> !exec_en)
    `VRTB_ASSERT(a_ram_op_fetches,
        (exec_en && (i_cmd.op == OP_WR_ADDR || i_cmd.op == OP_WR_DATA)) |=> (r_state == ST_FETCH))
    `VRTB_ASSERT(a_window_bit_kept,
        (exec_en && i_cmd.op == OP_WR_DATA) |=> (r_ram_address[15] == $past(r_ram_address[15])))
    `VRTB_ASSERT(a_result_not_lost, (r_out_valid && i_out_stall) |-> !exec_en)

endmodule

`default_nettype wire

// ===== sv/video_register_timer_block.sv =====
// path: a taken word is registered, queued, then executed into the output register
// throughput: one word a cycle while i_out_stall is low, for reads, register writes
//   and line or frame events; vram address and data writes add a refetch state
// reset: after i_rst_n the vram's 34816 words are swept to zero one word a cycle,
//   and o_in_stall stays high until the sweep is done
`default_nettype none

module video_register_timer_block (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire vrtb_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output vrtb_pkg::t_out_word      o_out_word
);
    import vrtb_pkg::*;

    t_q_stat q_stat;
    t_cmd    push_cmd, head_cmd;
    logic    push, pop, clearing;

    vrtb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_clearing (clearing),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    vrtb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_head  (head_cmd)
    );

    vrtb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire
